FILE: hdl/convex_shape_support_point_top_defines.svh
// Assertion macros for the convex shape support point block.
`ifndef CONVEX_SHAPE_SUPPORT_POINT_TOP_DEFINES_SVH
`define CONVEX_SHAPE_SUPPORT_POINT_TOP_DEFINES_SVH

// Implication check, disabled while reset is asserted.
`define CSSP_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("cssp check failed");

// Condition that must never be seen outside reset.
`define CSSP_ASSERT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("cssp check failed");

`endif

FILE: hdl/cssp_pkg.sv
// ----------------------------------------------------------------------------
// cssp_pkg
// Types and constants of the convex shape support point block.
// ----------------------------------------------------------------------------
package cssp_pkg;

	localparam int FRAC_BITS = 16;
	localparam logic [63:0] LIMIT_FULL = 64'd1 << (2 * FRAC_BITS);
	localparam logic [63:0] LIMIT_ROUNDED = (LIMIT_FULL + 64'd5000) / 64'd10000;
	localparam logic [31:0] NZ_LIMIT_RESET =
		(LIMIT_ROUNDED > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : LIMIT_ROUNDED[31:0];

	localparam logic [1:0] KIND_CUBE    = 2'd0;
	localparam logic [1:0] KIND_SPHERE  = 2'd1;
	localparam logic [1:0] KIND_CAPSULE = 2'd2;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	localparam int ROOT_W      = 32;
	localparam int QUO_W       = 31;
	localparam int SQRT_STAGES = ROOT_W;
	localparam int DIV_STAGES  = QUO_W;
	localparam int LATENCY     = 5 + SQRT_STAGES + DIV_STAGES + 1;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} query_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} point_t;

	// Per-item side information that rides along the pipeline
	typedef struct packed {
		logic [1:0]         kind;
		logic               tiny;
		logic               plus;
		logic [2:0]         dneg;
		logic               sneg;
		logic signed [31:0] hy;
		logic [2:0][31:0]   alt;
	} side_t;

endpackage

FILE: hdl/convex_shape_support_point_top.sv
// ----------------------------------------------------------------------------
// convex_shape_support_point_top
// Support point of a cube, sphere or capsule along a search direction.
// ----------------------------------------------------------------------------
// Usage:
//   Drive query and raise start; the item is taken at a rising edge with
//   start high and busy low. busy stays low, so an item may enter in every
//   cycle and one result leaves per cycle.
//   Each result shows on point for exactly one cycle with done high; the
//   receiver cannot hold it off, so nothing waits inside the block.
//   An item passes five front stages (capture, magnitudes and squares,
//   near-zero test and normalising shift, shifted squares and scaled
//   products, squared length), a 32-stage bit-per-stage square root and a
//   31-stage bit-per-stage divider per axis, then one output stage. The root
//   and divider stages set the depth.
//   The user writes near_zero_limit through limit_we/limit_wdata only while
//   idle; the block does not enforce this.
//   Reset clears every valid bit and loads the limit with its default; any
//   item in flight at reset is dropped.
// ----------------------------------------------------------------------------
module convex_shape_support_point_top
	import cssp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  query_t      query,
	input  logic        limit_we,
	input  logic [31:0] limit_wdata,
	output logic        done,
	output point_t      point
);

	// Magnitude of a signed word, exact for the most negative value
	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	logic [31:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= NZ_LIMIT_RESET;
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	// Never back-pressure the sender
	assign busy = 1'b0;

	// ---- stage 1: capture the item
	logic   v_s1;
	query_t q_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		q_s1 <= query;
	end

	// ---- stage 2: magnitudes, squares and the direct answers
	logic        v_s2;
	logic [31:0] m_s2   [3];
	logic [63:0] sq_s2  [3];
	logic [31:0] sabs_s2;
	side_t       side_s2;

	logic [31:0]        m_c [3];
	logic signed [31:0] h_c [3];
	logic [2:0]         dneg_c;
	side_t              side_c;

	always_comb begin
		m_c[0] = mag32(q_s1.dir_x);
		m_c[1] = mag32(q_s1.dir_y);
		m_c[2] = mag32(q_s1.dir_z);
		h_c[0] = q_s1.scale_x >>> 1;
		h_c[1] = q_s1.scale_y >>> 1;
		h_c[2] = q_s1.scale_z >>> 1;
		dneg_c = {q_s1.dir_z[31], q_s1.dir_y[31], q_s1.dir_x[31]};
		side_c      = '0;
		side_c.kind = q_s1.kind;
		side_c.dneg = dneg_c;
		side_c.sneg = q_s1.scale_x[31];
		side_c.hy   = h_c[1];
		side_c.plus = (q_s1.dir_y > 0 && h_c[1] > 0) || (q_s1.dir_y < 0 && h_c[1] < 0);
		for (int i = 0; i < 3; i++) begin
			if (q_s1.kind == KIND_CUBE) begin
				side_c.alt[i] = dneg_c[i] ? -h_c[i] : h_c[i];
			end else begin
				side_c.alt[i] = dneg_c[i] ? -h_c[0] : h_c[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			m_s2[i]  <= m_c[i];
			sq_s2[i] <= {32'd0, m_c[i]} * {32'd0, m_c[i]};
		end
		sabs_s2 <= mag32(q_s1.scale_x);
		side_s2 <= side_c;
	end

	// ---- stage 3: squared length, near-zero test, normalising shift
	logic        v_s3;
	logic [31:0] a_s3 [3];
	logic [31:0] sabs_s3;
	side_t       side_s3;

	logic [63:0] lensq_c;
	logic [31:0] big_c;
	logic [4:0]  sh_c;
	side_t       side_c3;

	always_comb begin
		lensq_c = sq_s2[0] + sq_s2[1] + sq_s2[2];
		big_c   = m_s2[0];
		if (m_s2[1] > big_c) begin
			big_c = m_s2[1];
		end
		if (m_s2[2] > big_c) begin
			big_c = m_s2[2];
		end
		// Shift that brings the largest magnitude into [2^30, 2^31); none if it is 0 or 2^31
		sh_c = '0;
		for (int i = 0; i < 31; i++) begin
			if (big_c[i]) begin
				sh_c = 5'(30 - i);
			end
		end
		if (big_c[31]) begin
			sh_c = '0;
		end
		side_c3      = side_s2;
		side_c3.tiny = (lensq_c < {32'd0, limit_q}) || (lensq_c == 64'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			a_s3[i] <= m_s2[i] << sh_c;
		end
		sabs_s3 <= sabs_s2;
		side_s3 <= side_c3;
	end

	// ---- stage 4: squares of the shifted magnitudes and scaled numerators
	logic        v_s4;
	logic [63:0] asq_s4 [3];
	logic [63:0] num_s4 [3];
	side_t       side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			asq_s4[i] <= {32'd0, a_s3[i]} * {32'd0, a_s3[i]};
			num_s4[i] <= {32'd0, sabs_s3} * {32'd0, a_s3[i]};
		end
		side_s4 <= side_s3;
	end

	// ---- stage 5 and square root: index 0 holds the squared length,
	// each later index one more root bit
	logic              rt_v_s    [SQRT_STAGES+1];
	logic [63:0]       rt_x_s    [SQRT_STAGES+1];
	logic [33:0]       rt_rem_s  [SQRT_STAGES+1];
	logic [ROOT_W-1:0] rt_root_s [SQRT_STAGES+1];
	logic [63:0]       rt_num_s  [SQRT_STAGES+1][3];
	side_t             rt_side_s [SQRT_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v_s[0] <= 1'b0;
		end else begin
			rt_v_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		rt_x_s[0]    <= asq_s4[0] + asq_s4[1] + asq_s4[2];
		rt_rem_s[0]  <= '0;
		rt_root_s[0] <= '0;
		for (int i = 0; i < 3; i++) begin
			rt_num_s[0][i] <= num_s4[i];
		end
		rt_side_s[0] <= side_s4;
	end

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		logic [33:0] rem2;
		logic [33:0] trial;
		logic        take;

		always_comb begin
			rem2  = {rt_rem_s[k][31:0], rt_x_s[k][63:62]};
			trial = {rt_root_s[k], 2'b01};
			take  = rem2 >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rt_x_s[k+1]    <= {rt_x_s[k][61:0], 2'b00};
			rt_rem_s[k+1]  <= take ? (rem2 - trial) : rem2;
			rt_root_s[k+1] <= {rt_root_s[k][ROOT_W-2:0], take};
			for (int i = 0; i < 3; i++) begin
				rt_num_s[k+1][i] <= rt_num_s[k][i];
			end
			rt_side_s[k+1] <= rt_side_s[k];
		end
	end

	// ---- divider: one quotient bit per stage, most significant first
	logic             dv_v_s    [DIV_STAGES];
	logic [63:0]      dv_rem_s  [DIV_STAGES][3];
	logic [QUO_W-1:0] dv_quo_s  [DIV_STAGES][3];
	logic [ROOT_W:0]  dv_dvs_s  [DIV_STAGES];
	side_t            dv_side_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		localparam int J = QUO_W - 1 - k;

		logic             v_in;
		logic [63:0]      rem_in [3];
		logic [QUO_W-1:0] quo_in [3];
		logic [QUO_W-1:0] quo_nx [3];
		logic [ROOT_W:0]  dvs_in;
		side_t            side_in;
		logic [63:0]      dsh;
		logic [2:0]       take;

		if (k == 0) begin : g_first
			always_comb begin
				v_in    = rt_v_s[SQRT_STAGES];
				dvs_in  = {rt_root_s[SQRT_STAGES], 1'b0};
				side_in = rt_side_s[SQRT_STAGES];
				for (int i = 0; i < 3; i++) begin
					rem_in[i] = rt_num_s[SQRT_STAGES][i];
					quo_in[i] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				v_in    = dv_v_s[k-1];
				dvs_in  = dv_dvs_s[k-1];
				side_in = dv_side_s[k-1];
				for (int i = 0; i < 3; i++) begin
					rem_in[i] = dv_rem_s[k-1][i];
					quo_in[i] = dv_quo_s[k-1][i];
				end
			end
		end

		always_comb begin
			dsh = {{(63 - ROOT_W){1'b0}}, dvs_in} << J;
			for (int i = 0; i < 3; i++) begin
				take[i]      = rem_in[i] >= dsh;
				quo_nx[i]    = quo_in[i];
				quo_nx[i][J] = take[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else begin
				dv_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[k][i] <= take[i] ? (rem_in[i] - dsh) : rem_in[i];
				dv_quo_s[k][i] <= quo_nx[i];
			end
			dv_dvs_s[k]  <= dvs_in;
			dv_side_s[k] <= side_in;
		end
	end

	// ---- output stage: sign the terms, pick by shape, saturate
	logic   vld_out_q;
	point_t point_q;

	side_t              fs;
	logic signed [31:0] term [3];
	logic signed [33:0] ysum;
	logic signed [31:0] ysat;
	point_t             pt_c;

	always_comb begin
		fs = dv_side_s[DIV_STAGES-1];
		for (int i = 0; i < 3; i++) begin
			if (fs.sneg ^ fs.dneg[i]) begin
				term[i] = -$signed({1'b0, dv_quo_s[DIV_STAGES-1][i]});
			end else begin
				term[i] = $signed({1'b0, dv_quo_s[DIV_STAGES-1][i]});
			end
		end
		ysum = fs.plus ? (34'(term[1]) + 34'(fs.hy)) : (34'(term[1]) - 34'(fs.hy));
		if (ysum > 34'sd2147483647) begin
			ysat = 32'sh7FFF_FFFF;
		end else if (ysum < -34'sd2147483648) begin
			ysat = 32'sh8000_0000;
		end else begin
			ysat = ysum[31:0];
		end
		case (fs.kind)
			KIND_CUBE: begin
				pt_c = {fs.alt[0], fs.alt[1], fs.alt[2]};
			end
			KIND_SPHERE: begin
				if (fs.tiny) begin
					pt_c = {fs.alt[0], fs.alt[1], fs.alt[2]};
				end else begin
					pt_c = {term[0], term[1], term[2]};
				end
			end
			KIND_CAPSULE: begin
				if (fs.tiny) begin
					pt_c = '0;
				end else begin
					pt_c = {term[0], ysat, term[2]};
				end
			end
			default: begin
				pt_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else begin
			vld_out_q <= dv_v_s[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		point_q <= pt_c;
	end

	assign done  = vld_out_q;
	assign point = point_q;

endmodule

FILE: hdl/cssp_checker.sv
// ----------------------------------------------------------------------------
// cssp_checker
// Port-level checks of the convex shape support point block.
// ----------------------------------------------------------------------------
`include "convex_shape_support_point_top_defines.svh"

module cssp_checker
	import cssp_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   start,
	input logic   busy,
	input query_t query,
	input logic   done,
	input point_t point
);

	`CSSP_ASSERT_NEVER(a_never_busy, clk, arst_n, busy)
	`CSSP_ASSERT_IMPL(a_done_has_item, clk, arst_n, done, $past(start && !busy, LATENCY))
	`CSSP_ASSERT_IMPL(a_unknown_kind_zero, clk, arst_n, done && $past(query.kind == KIND_NONE, LATENCY), point == '0)
	`CSSP_ASSERT_IMPL(a_cube_sign, clk, arst_n, done && $past(query.kind == KIND_CUBE && !query.dir_x[31] && !query.scale_x[31], LATENCY), !point.point_x[31])

endmodule

bind convex_shape_support_point_top cssp_checker u_cssp_checker (.*);
